[src/samq_pkg.sv]
package samq_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LIM_W     = 5;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned DEPTH_DEF = 16;

  localparam logic [LIM_W-1:0] LIMIT_RST = 5'd16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Result of one item, handed from the sequencer to the output register.
  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] removed_value;
    logic [OCC_W-1:0]         occupancy;
  } res_t;

endpackage

[src/samq_in_if.sv]
interface samq_in_if;
  import samq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);

endinterface

[src/samq_out_if.sv]
interface samq_out_if;
  import samq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] removed_value;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output status, output removed_value, output occupancy,
                  input ready);
  modport sink (input valid, input status, input removed_value, input occupancy,
                output ready);

endinterface

[src/sorted_array_min_priority_queue.sv]
// Channel   Dir  Beat contents                               Accepted when
// in_i      in   operation, value                            valid && ready
// out_o     out  status, removed_value, occupancy            valid && ready
// cfg       in   cfg_wdata_i = capacity limit                cfg_we_i
//
// One item at a time; the store sits in a single-port-read RAM and one compare is
// made per cycle. An insert moves each stored value larger than it up a slot; a
// remove reads the head and moves the values left down a slot. Refused items and
// an insert into an empty store go straight to the result.
// Reset empties the queue at once and sets the limit to 16; no clearing pass.
// A result waiting in the output register does not stop the next beat being taken.
module sorted_array_min_priority_queue #(
  parameter int unsigned DEPTH = samq_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [samq_pkg::LIM_W-1:0] cfg_wdata_i,
  samq_in_if.sink                    in_i,
  samq_out_if.source                 out_o
);
  import samq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [LIM_W-1:0] limit_q;
  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_q.status;
  assign out_o.removed_value = out_q.removed_value;
  assign out_o.occupancy     = out_q.occupancy;

  samq_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .limit_i     (limit_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  samq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

[src/samq_ram.sv]
module samq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/samq_seq.sv]
module samq_seq #(
  parameter int unsigned DEPTH = samq_pkg::DEPTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  samq_in_if.sink                                      in_i,
  input  logic [samq_pkg::LIM_W-1:0]                   limit_i,
  output logic                                         res_valid_o,
  input  logic                                         res_ready_i,
  output samq_pkg::res_t                               res_o,
  output logic                                         ram_we_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_waddr_o,
  output logic [samq_pkg::DATA_W-1:0]                  ram_wdata_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] ram_raddr_o,
  input  logic [samq_pkg::DATA_W-1:0]                  ram_rdata_i
);
  import samq_pkg::*;

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > LIM_W) ? CW : LIM_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_RD   = 3'd1;
  localparam logic [2:0] S_INS_CMP  = 3'd2;
  localparam logic [2:0] S_INS_LAST = 3'd3;
  localparam logic [2:0] S_REM_RD   = 3'd4;
  localparam logic [2:0] S_REM_HEAD = 3'd5;
  localparam logic [2:0] S_REM_MOV  = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  logic [2:0]               state_q, state_d;
  logic                     op_q, op_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [AW-1:0]            pos_q, pos_d;
  logic [AW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            count_q, count_d;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] removed_q, removed_d;

  logic          full;
  logic          le;
  logic [AW-1:0] last_idx;

  // The limit saturates at the store depth.
  assign full = (CMPW'(count_q) >= CMPW'(limit_i)) || (CMPW'(count_q) >= CMPW'(DEPTH));
  assign le   = $signed(ram_rdata_i) <= val_q;
  assign last_idx = AW'(count_q - CW'(1));

  assign in_i.ready  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_o.status        = status_q;
  assign res_o.removed_value = removed_q;
  assign res_o.occupancy     = OCC_W'(count_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    count_d     = count_q;
    status_d    = status_q;
    removed_d   = removed_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = val_q;
    ram_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d      = in_i.operation;
          val_d     = in_i.value;
          removed_d = '0;
          status_d  = ST_DONE;
          pos_d     = AW'(count_q);
          if (in_i.operation == OP_INSERT) begin
            if (full) begin
              status_d = ST_FULL;
              state_d  = S_RESP;
            end else if (count_q == '0) begin
              ram_we_o    = 1'b1;
              ram_wdata_o = in_i.value;
              count_d     = count_q + CW'(1);
              state_d     = S_RESP;
            end else begin
              state_d = S_INS_RD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_RESP;
            end else begin
              state_d = S_REM_RD;
            end
          end
        end
      end
      S_INS_RD: begin
        ram_raddr_o = pos_q - AW'(1);
        state_d     = S_INS_CMP;
      end
      S_INS_CMP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q;
        if (le) begin
          count_d = count_q + CW'(1);
          state_d = S_RESP;
        end else begin
          // The larger value moves up one slot and the search goes on below it.
          ram_wdata_o = ram_rdata_i;
          pos_d       = pos_q - AW'(1);
          ram_raddr_o = pos_q - AW'(2);
          if (pos_q == AW'(1)) begin
            state_d = S_INS_LAST;
          end
        end
      end
      S_INS_LAST: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = '0;
        count_d     = count_q + CW'(1);
        state_d     = S_RESP;
      end
      S_REM_RD: begin
        ram_raddr_o = '0;
        state_d     = S_REM_HEAD;
      end
      S_REM_HEAD: begin
        removed_d = ram_rdata_i;
        if (count_q == CW'(1)) begin
          count_d = count_q - CW'(1);
          state_d = S_RESP;
        end else begin
          ram_raddr_o = AW'(1);
          idx_d       = AW'(1);
          state_d     = S_REM_MOV;
        end
      end
      S_REM_MOV: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = idx_q - AW'(1);
        ram_wdata_o = ram_rdata_i;
        if (idx_q == last_idx) begin
          count_d = count_q - CW'(1);
          state_d = S_RESP;
        end else begin
          ram_raddr_o = idx_q + AW'(1);
          idx_d       = idx_q + AW'(1);
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    pos_q     <= pos_d;
    idx_q     <= idx_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(count_q) <= CMPW'(DEPTH))
    else $error("stored count above depth");

  a_empty_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && status_q == ST_EMPTY) |-> (count_q == '0))
    else $error("empty status with values stored");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_CMP && le) |=> (count_q == CW'($past(count_q) + CW'(1))))
    else $error("insert did not raise the count by one");

  a_shift_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_CMP) |-> (pos_q != '0))
    else $error("insert search ran below the bottom slot");

  a_resp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && !res_ready_i) |=> (state_q == S_RESP && $stable(count_q)))
    else $error("result withdrawn before it was taken");
`endif

endmodule

[tb/sv/tb_sorted_array_min_priority_queue.sv]
module tb_sorted_array_min_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import samq_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEF;
  localparam int unsigned STALL_LEN  = 300;
  localparam int unsigned QUIET_MAX  = 5000;

  typedef struct {
    logic                     operation;
    logic signed [DATA_W-1:0] value;
  } queue_op_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LIM_W-1:0] cfg_wdata;

  samq_in_if  in_bus ();
  samq_out_if out_bus ();

  sorted_array_min_priority_queue #(
    .DEPTH (DEPTH)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // Stimulus waiting to be offered, and results due back in order.
  queue_op_t                pending_ops[$];
  res_t                     due_results[$];

  // Own copy of the queue contents and the capacity register.
  logic signed [DATA_W-1:0] model_sorted[$];
  logic [LIM_W-1:0]         model_limit;

  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_refused_full;
  int unsigned n_refused_empty;
  int unsigned n_errors;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          stall_req;
  bit          stall_ack;
  bit          steady_flow;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic res_t apply_queue_op(input logic operation,
                                          input logic signed [DATA_W-1:0] value);
    res_t        res;
    int unsigned room;
    int unsigned pos;
    room = (32'(model_limit) > DEPTH) ? DEPTH : 32'(model_limit);
    res.status        = ST_DONE;
    res.removed_value = '0;
    if (operation == OP_INSERT) begin
      if (model_sorted.size() >= room) begin
        res.status = ST_FULL;
      end else begin
        // Equal values go behind the ones already held, so they leave in arrival order.
        pos = 0;
        while (pos < model_sorted.size() && model_sorted[pos] <= value) pos++;
        model_sorted.insert(pos, value);
      end
    end else begin
      if (model_sorted.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_value = model_sorted.pop_front();
      end
    end
    res.occupancy = OCC_W'(model_sorted.size());
    return res;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $signed($urandom_range(16)) - 8;
      5, 6, 7:       v = $urandom;
      8: begin
        case ($urandom_range(3))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default:       v = $signed($urandom_range(1000)) - 500;
    endcase
    return v;
  endfunction

  task automatic add_op(input logic operation, input logic signed [DATA_W-1:0] value);
    queue_op_t op;
    op.operation = operation;
    op.value     = value;
    pending_ops.push_back(op);
  endtask

  task automatic add_random_ops(input int unsigned count, input int unsigned insert_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < insert_pct) add_op(OP_INSERT, pick_value());
      else add_op(OP_REMOVE, $urandom);
    end
  endtask

  // The check runs just after the edge, once the driver's updates have settled.
  task automatic wait_idle();
    while (pending_ops.size() != 0 || due_results.size() != 0 || in_bus.valid) begin
      @(posedge clk);
      #1;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] lim);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_limit = lim;
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t result %0d: %s", $time, n_checked, what);
    n_errors++;
  endtask

  // Driver: a new beat is offered only once the previous one has been taken.
  always @(posedge clk) begin
    queue_op_t op;
    bit        offer;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        due_results.push_back(apply_queue_op(in_bus.operation, in_bus.value));
        n_sent++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        offer = pending_ops.size() != 0 && (steady_flow || $urandom_range(99) >= 38);
        if (offer) begin
          op = pending_ops.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.operation <= op.operation;
          in_bus.value     <= op.value;
        end else begin
          in_bus.valid     <= 1'b0;
          in_bus.operation <= 1'($urandom_range(1));
          in_bus.value     <= $urandom;
        end
      end
    end
  end

  // Long receiver hold-off, started by a toggle of stall_req.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_req != stall_ack) begin
      stall_left <= STALL_LEN;
      stall_ack  <= stall_req;
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = due_results.pop_front();
          if (out_bus.status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d", out_bus.status, want.status));
          if (out_bus.removed_value !== want.removed_value)
            report_mismatch($sformatf("removed_value %0d, wanted %0d",
                                      out_bus.removed_value, want.removed_value));
          if (out_bus.occupancy !== want.occupancy)
            report_mismatch($sformatf("occupancy %0d, wanted %0d",
                                      out_bus.occupancy, want.occupancy));
          if (want.status == ST_FULL) n_refused_full++;
          if (want.status == ST_EMPTY) n_refused_empty++;
        end
        n_checked++;
      end
      out_bus.ready <= (stall_left == 0) && (steady_flow || $urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("timeout: no beat moved for %0d cycles", QUIET_MAX);
        $display("tb_sorted_array_min_priority_queue: errors");
        $finish;
      end
    end
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_INSERT;
    in_bus.value     = '0;
    out_bus.ready    = 1'b0;
    model_limit      = LIMIT_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty remove, value extremes, duplicates, fill to the full depth.
    add_op(OP_REMOVE, 32'sh1234_5678);
    add_op(OP_INSERT, 32'sh7FFF_FFFF);
    add_op(OP_INSERT, 32'sh8000_0000);
    add_op(OP_INSERT, 0);
    add_op(OP_INSERT, -1);
    add_op(OP_INSERT, 1);
    add_op(OP_INSERT, 5);
    add_op(OP_INSERT, 5);
    add_op(OP_INSERT, -5);
    for (int i = 0; i < 8; i++) add_op(OP_INSERT, pick_value());
    add_op(OP_INSERT, 42);
    for (int i = 0; i < 3; i++) add_op(OP_REMOVE, $urandom);
    wait_idle();

    // A limit above the depth behaves as the depth.
    write_limit(5'd31);
    add_random_ops(120, 60);
    wait_idle();

    // Limit most likely below the count: inserts refused until removes catch up.
    write_limit(5'd3);
    add_random_ops(60, 50);
    wait_idle();

    write_limit(5'd0);
    add_random_ops(40, 60);
    wait_idle();

    write_limit(5'd1);
    add_random_ops(60, 60);
    wait_idle();

    write_limit(5'd17);
    @(posedge clk);
    steady_flow <= 1'b1;
    add_random_ops(150, 65);
    wait_idle();
    steady_flow <= 1'b0;

    // The receiver holds off while the sender keeps offering, so the input backs up.
    write_limit(5'd16);
    add_random_ops(150, 35);
    @(posedge clk);
    stall_req <= ~stall_req;
    wait_idle();

    write_limit(5'd2);
    add_random_ops(80, 55);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      write_limit(LIM_W'($urandom_range(31)));
      add_random_ops(60, (p % 2 == 0) ? 70 : 35);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    $display("Covered %0d operations and %0d results over several capacity limits,",
             n_sent, n_checked);
    $display("with %0d inserts refused as full and %0d removes refused as empty.",
             n_refused_full, n_refused_empty);
    if (n_errors == 0) begin
      $display("tb_sorted_array_min_priority_queue: clean");
    end else begin
      $display("tb_sorted_array_min_priority_queue: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
src/samq_pkg.sv
src/samq_in_if.sv
src/samq_out_if.sv
src/samq_ram.sv
src/samq_seq.sv
src/sorted_array_min_priority_queue.sv
tb/sv/tb_sorted_array_min_priority_queue.sv
